>>> design/pph_pkg.sv
// Shared constants, codes and types of the PPG peak heart-rate estimator.
package pph_pkg;

   // Field widths
   localparam int SAMPLE_W  = 16;
   localparam int TIME_W    = 32;
   localparam int RATE_W    = 16;
   localparam int HR_W      = 8;
   localparam int LEN_W     = 3;
   localparam int SUM_W     = 19;
   localparam int QUO_W     = 19;
   localparam int DIVISOR_W = 16;

   // Peak window geometry
   localparam int WINDOW_DEPTH = 7;
   localparam int WIN_FILL_W   = 3;

   // Rate history depth default
   localparam int HISTORY_DEPTH_DEF = 7;

   // Beats-per-minute numerator over a millisecond interval
   localparam logic [QUO_W-1:0] RATE_NUMERATOR = QUO_W'(60000);

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PEAK_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VALID_RATES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_LENGTH    = 2'd2;

   // Register reset values
   localparam logic [15:0]      MIN_PEAK_INTERVAL_RST = 16'd320;
   localparam logic [LEN_W-1:0] MIN_VALID_RATES_RST   = 3'd3;
   localparam logic [LEN_W-1:0] AVERAGE_LENGTH_RST    = 3'd5;

   // Commands from the sequencer to the rate history
   typedef struct packed {
      logic             drop;
      logic             append;
      logic             sum_start;
      logic [LEN_W-1:0] len;
   } hist_cmd_type;

   // Peak detector status toward the sequencer
   typedef struct packed {
      logic                 accepted;
      logic                 gap_big;
      logic [DIVISOR_W-1:0] gap_low;
   } peak_stat_type;

endpackage

>>> design/pph_chan_if.sv
// Valid/ready channel interfaces for the sample input and the rate output.
interface pph_req_if;
   import pph_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic [TIME_W-1:0]   timestamp_ms;

   modport source (output valid, output sample, output timestamp_ms, input ready);
   modport sink   (input valid, input sample, input timestamp_ms, output ready);
endinterface

interface pph_rsp_if;
   import pph_pkg::*;

   logic            valid;
   logic            ready;
   logic [HR_W-1:0] heart_rate;

   modport source (output valid, output heart_rate, input ready);
   modport sink   (input valid, input heart_rate, output ready);
endinterface

>>> design/pph_peak_detect.sv
// Seven-sample value/time window, peak test and last-peak tracking.
module pph_peak_detect (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [pph_pkg::SAMPLE_W-1:0]   sample,
   input  logic [pph_pkg::TIME_W-1:0]     timestamp_ms,
   input  logic                           check,
   input  logic [15:0]                    min_peak_interval,
   output pph_pkg::peak_stat_type         stat
);
   import pph_pkg::*;

   logic [SAMPLE_W-1:0]   samp_ff [WINDOW_DEPTH];
   logic [SAMPLE_W-1:0]   samp_in [WINDOW_DEPTH];
   logic [TIME_W-1:0]     time_ff [WINDOW_DEPTH];
   logic [TIME_W-1:0]     time_in [WINDOW_DEPTH];
   logic [WIN_FILL_W-1:0] fill_ff, fill_in;
   logic [TIME_W-1:0]     last_ff, last_in;

   logic                  full;
   logic                  is_peak;
   logic [TIME_W-1:0]     gap;
   logic                  accepted;

   assign full = (fill_ff == WIN_FILL_W'(WINDOW_DEPTH));

   // Window update: fill up from the bottom, then shift down once full
   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         samp_in[i] = samp_ff[i];
         time_in[i] = time_ff[i];
      end
      fill_in = fill_ff;
      if (push) begin
         if (full) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
               samp_in[i] = samp_ff[i+1];
               time_in[i] = time_ff[i+1];
            end
            samp_in[WINDOW_DEPTH-1] = sample;
            time_in[WINDOW_DEPTH-1] = timestamp_ms;
         end else begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
               if (fill_ff == WIN_FILL_W'(i)) begin
                  samp_in[i] = sample;
                  time_in[i] = timestamp_ms;
               end
            end
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // Centre sample against its neighbors; outermost ones must be strictly lower
   assign is_peak = (samp_ff[3] >= samp_ff[2]) && (samp_ff[3] >= samp_ff[1]) &&
                    (samp_ff[3] >  samp_ff[0]) && (samp_ff[3] >= samp_ff[4]) &&
                    (samp_ff[3] >= samp_ff[5]) && (samp_ff[3] >  samp_ff[6]);

   // Interval since last accepted peak, modulo 2^32
   assign gap      = time_ff[3] - last_ff;
   assign accepted = is_peak && (gap > {16'b0, min_peak_interval});

   always_comb begin
      last_in = last_ff;
      if (check && accepted) begin
         last_in = time_ff[3];
      end
   end

   assign stat.accepted = accepted;
   assign stat.gap_big  = (gap[TIME_W-1:DIVISOR_W] != '0);
   assign stat.gap_low  = gap[DIVISOR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            samp_ff[i] <= '0;
            time_ff[i] <= '0;
         end
         fill_ff <= '0;
         last_ff <= '0;
      end else begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            samp_ff[i] <= samp_in[i];
            time_ff[i] <= time_in[i];
         end
         fill_ff <= fill_in;
         last_ff <= last_in;
      end
   end

endmodule

>>> design/pph_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module pph_serial_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pph_pkg::QUO_W-1:0]      dividend,
   input  logic [pph_pkg::DIVISOR_W-1:0]  divisor,
   output logic                           done,
   output logic [pph_pkg::QUO_W-1:0]      quotient
);
   import pph_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);

   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W+1:0] diff;

   // Next partial remainder takes the top dividend bit; trial subtract
   assign shifted = {rem_ff, quo_ff[QUO_W-1]};
   assign diff    = {1'b0, shifted} - {2'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W+1]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/pph_rate_history.sv
// Shifting rate history with count and a one-entry-per-cycle summing walk.
module pph_rate_history #(
   parameter int HISTORY_DEPTH = pph_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pph_pkg::hist_cmd_type                 cmd,
   input  logic [pph_pkg::RATE_W-1:0]            rate,
   output logic [$clog2(HISTORY_DEPTH+1)-1:0]    count,
   output logic                                  sum_done,
   output logic [pph_pkg::SUM_W-1:0]             sum
);
   import pph_pkg::*;

   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int IDX_W = $clog2(HISTORY_DEPTH);

   logic [RATE_W-1:0] hist_ff [HISTORY_DEPTH];
   logic [RATE_W-1:0] hist_in [HISTORY_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic              full;
   logic [CNT_W-1:0]  start_idx;

   assign full      = (count_ff == CNT_W'(HISTORY_DEPTH));
   assign start_idx = count_ff - CNT_W'(cmd.len);

   // Storage: drop oldest when full, append at the count
   always_comb begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
      end
      count_in = count_ff;
      if (cmd.drop && full) begin
         for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            hist_in[i] = hist_ff[i+1];
         end
         count_in = count_ff - 1'b1;
      end else if (cmd.append) begin
         hist_in[count_ff[IDX_W-1:0]] = rate;
         count_in = count_ff + 1'b1;
      end
   end

   // Summing walk over the newest len entries
   always_comb begin
      ptr_in  = ptr_ff;
      left_in = left_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.sum_start) begin
         ptr_in  = start_idx[IDX_W-1:0];
         left_in = cmd.len;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = acc_ff + SUM_W'(hist_ff[ptr_ff]);
         ptr_in  = ptr_ff + 1'b1;
         left_in = left_ff - 1'b1;
         if (left_ff == LEN_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         hist_ff[i] <= hist_in[i];
      end
      ptr_ff  <= ptr_in;
      left_ff <= left_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign count    = count_ff;
   assign sum_done = done_ff;
   assign sum      = acc_ff;

endmodule

>>> design/ppg_peak_heart_rate.sv
// Top level of the PPG peak-interval heart-rate estimator.
//
// Usage: each transfer on req_ch carries one optical sample and its
// millisecond timestamp; each accepted sample yields exactly one transfer
// on rsp_ch holding the current heart rate in beats per minute (zero until
// enough peak intervals have been seen). The user writes registers through
// the csr_ port only while the block is idle; the block does not enforce it.
// Index 0 minimum peak interval, 1 rates needed before the output updates,
// 2 averaging length.
// Operation: one sample is in work at a time; one that is not an accepted peak
// skips the steps below. An accepted peak runs a 19-step serial divide for the
// rate (skipped when the interval exceeds 65535 ms), a walk summing up to 7
// history entries and a second 19-step divide for the mean (both skipped when
// too few rates are held); both divides share the one bit-serial divider.
// The result waits in an output register, so the next sample is taken while
// the receiver stalls; only its own result then waits for rsp_ch.ready.
// Reset (synchronous): window zeroed, history empty, rate zero, registers at
// their defaults; ready rises in the first cycle after reset.
module ppg_peak_heart_rate #(
   parameter int HISTORY_DEPTH = pph_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   pph_req_if.sink                           req_ch,
   pph_rsp_if.source                         rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [pph_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pph_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import pph_pkg::*;

   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CHECK    = 3'd1;
   localparam logic [2:0] S_DIV_RATE = 3'd2;
   localparam logic [2:0] S_POST     = 3'd3;
   localparam logic [2:0] S_SUM      = 3'd4;
   localparam logic [2:0] S_DIV_MEAN = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [HR_W-1:0]  rate_ff, rate_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [HR_W-1:0]  rsp_hr_ff, rsp_hr_in;

   logic [15:0]      min_int_ff;
   logic [LEN_W-1:0] min_valid_ff;
   logic [LEN_W-1:0] avg_len_ff;

   logic             push;
   logic             check;
   peak_stat_type    stat;

   logic             div_start;
   logic [QUO_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0] div_divisor;
   logic             div_done;
   logic [QUO_W-1:0] div_quo;

   hist_cmd_type     hcmd;
   logic [RATE_W-1:0] append_rate;
   logic [CNT_W-1:0] hist_count;
   logic             sum_done;
   logic [SUM_W-1:0] hist_sum;

   logic [CMP_W-1:0] cnt_ext, avg_ext, mv_ext;
   logic [LEN_W-1:0] len_sel;

   // Register writes; unknown index is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         min_int_ff   <= MIN_PEAK_INTERVAL_RST;
         min_valid_ff <= MIN_VALID_RATES_RST;
         avg_len_ff   <= AVERAGE_LENGTH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_PEAK_INTERVAL: min_int_ff   <= csr_wr_data[15:0];
            CSR_MIN_VALID_RATES:   min_valid_ff <= csr_wr_data[LEN_W-1:0];
            CSR_AVERAGE_LENGTH:    avg_len_ff   <= csr_wr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   pph_peak_detect u_peak (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .sample            (req_ch.sample),
      .timestamp_ms      (req_ch.timestamp_ms),
      .check             (check),
      .min_peak_interval (min_int_ff),
      .stat              (stat)
   );

   pph_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   pph_rate_history #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock    (clock),
      .reset    (reset),
      .cmd      (hcmd),
      .rate     (append_rate),
      .count    (hist_count),
      .sum_done (sum_done),
      .sum      (hist_sum)
   );

   // Averaging length: newest min(count, average_length) rates
   assign cnt_ext = CMP_W'(hist_count);
   assign avg_ext = CMP_W'(avg_len_ff);
   assign mv_ext  = CMP_W'(min_valid_ff);
   assign len_sel = (cnt_ext > avg_ext) ? avg_len_ff : LEN_W'(hist_count);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      rate_in       = rate_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_hr_in     = rsp_hr_ff;
      push          = 1'b0;
      check         = 1'b0;
      div_start     = 1'b0;
      div_dividend  = RATE_NUMERATOR;
      div_divisor   = stat.gap_low;
      hcmd          = '0;
      hcmd.len      = len_sel;
      append_rate   = div_quo[RATE_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               push      = 1'b1;
               hcmd.drop = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            check = 1'b1;
            if (!stat.accepted) begin
               state_in = S_FINISH;
            end else if (stat.gap_big) begin
               // interval above 65535 ms: rate truncates to zero
               hcmd.append = 1'b1;
               append_rate = '0;
               state_in    = S_POST;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV_RATE;
            end
         end
         S_DIV_RATE: begin
            if (div_done) begin
               hcmd.append = 1'b1;
               state_in    = S_POST;
            end
         end
         S_POST: begin
            if (cnt_ext >= mv_ext) begin
               if (len_sel == '0) begin
                  rate_in  = '0;
                  state_in = S_FINISH;
               end else begin
                  hcmd.sum_start = 1'b1;
                  state_in       = S_SUM;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SUM: begin
            if (sum_done) begin
               div_start    = 1'b1;
               div_dividend = hist_sum;
               div_divisor  = DIVISOR_W'(len_sel);
               state_in     = S_DIV_MEAN;
            end
         end
         S_DIV_MEAN: begin
            if (div_done) begin
               rate_in  = div_quo[HR_W-1:0];
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hr_in    = rate_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      rsp_hr_ff <= rsp_hr_in;
   end

   assign req_ch.ready      = (state_ff == S_IDLE) && !reset;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.heart_rate = rsp_hr_ff;

endmodule
